### design/rwrc_pkg.sv
package rwrc_pkg;

	localparam int RING_DEPTH = 64;
	localparam int SEQ_W = 32;
	localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int CW = $clog2(RING_DEPTH + 1);

	typedef enum logic {
		REQ_CHECK  = 1'b0,
		REQ_COMMIT = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;       // capture the incoming sequence number
		logic write;      // commit it into the ring
		logic rd_oldest;  // read the slot at the write pointer
		logic scan_start; // read slot zero and start the duplicate scan
		logic scan_step;  // read the next slot of the scan
		logic res_load;   // load the verdict register
		logic res_val;    // verdict to load
		logic out_load;   // move the verdict into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic seq_zero;
		logic seq_later;
		logic ring_full;
		logic ring_empty;
		logic seq_older;
		logic hit;
		logic scan_done;
	} sts_t;

endpackage

### design/replay_window_ring_check.sv
// A commit word loads its verdict as it is accepted and goes to delivery; a
// check word is judged against the latest number and the oldest slot, then,
// unless an early exit applies, scans the filled entries for a duplicate. A
// new word is taken in the cycle after the previous result is loaded into the
// output register; the single ring read port sets the one-entry-per-cycle scan.
// Reset (arst_n low) clears pointer, fill count, latest number and output valid.
module replay_window_ring_check import rwrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             req_type,
	input  logic [SEQ_W-1:0] sequence_number,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             rejected
);

	// The controller sequences one word at a time: accept, judge a check against
	// the latest number and the oldest slot, then, unless that settles it, scan the
	// filled slots one per cycle for a duplicate. The verdict sits in an output
	// register, so a new word can be accepted while a finished one waits there.
	cmd_t cmd;
	sts_t sts;

	rwrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the ring memory, the write pointer, the fill count,
	// the latest committed number and the serial comparators.
	rwrc_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.sequence_number (sequence_number),
		.cmd             (cmd),
		.sts             (sts),
		.rejected        (rejected)
	);

endmodule

### design/rwrc_ctrl.sv
module rwrc_ctrl import rwrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready  = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (req_type == REQ_COMMIT) ? ST_DONE : ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (sts.seq_zero || sts.seq_later || (sts.ring_full && sts.seq_older) ||
				    sts.ring_empty) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.hit || sts.scan_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take      = 1'b1;
					cmd.rd_oldest = 1'b1;
					if (req_type == REQ_COMMIT) begin
						cmd.write    = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_val  = 1'b0;
					end
				end
			end
			ST_EVAL: begin
				if (sts.seq_zero) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b1;
				end else if (sts.seq_later) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b0;
				end else if (sts.ring_full && sts.seq_older) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b1;
				end else if (sts.ring_empty) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b0;
				end else begin
					cmd.scan_start = 1'b1;
				end
			end
			ST_SCAN: begin
				if (sts.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b1;
				end else if (sts.scan_done) begin
					cmd.res_load = 1'b1;
					cmd.res_val  = 1'b0;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.out_load = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A waiting word is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output word overwritten before it was taken");

	// A commit goes straight to delivery.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && req_type == REQ_COMMIT) |=> (state_q == ST_DONE))
		else $error("commit did not go straight to delivery");

	// The scan only runs over a ring that holds entries.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !sts.ring_empty)
		else $error("duplicate scan over an empty ring");

endmodule

### design/rwrc_dp.sv
module rwrc_dp import rwrc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SEQ_W-1:0] sequence_number,
	input  cmd_t             cmd,
	output sts_t             sts,
	output logic             rejected
);

	logic [SEQ_W-1:0] ring_mem [RING_DEPTH];
	logic [SEQ_W-1:0] rd_data_q;
	logic [SEQ_W-1:0] seq_q;
	logic [SEQ_W-1:0] latest_q;
	logic [AW-1:0]    wp_q;
	logic [CW-1:0]    fill_q;
	logic [CW-1:0]    scan_cnt_q;
	logic             res_q;
	logic             rejected_q;
	logic [AW-1:0]    rd_addr;
	logic [SEQ_W-1:0] d_new;
	logic [SEQ_W-1:0] d_lat;
	logic [SEQ_W-1:0] d_old;

	always_comb begin
		rd_addr = wp_q;
		if (cmd.rd_oldest) begin
			rd_addr = wp_q;
		end else if (cmd.scan_start) begin
			rd_addr = '0;
		end else if (cmd.scan_step) begin
			rd_addr = scan_cnt_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && cmd.write) begin
			ring_mem[wp_q] <= sequence_number;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	// Serial differences: incoming against latest on commit, captured against
	// latest and against the oldest slot on check.
	assign d_new = sequence_number - latest_q;
	assign d_lat = seq_q - latest_q;
	assign d_old = seq_q - rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			fill_q     <= '0;
			latest_q   <= '0;
			scan_cnt_q <= '0;
		end else begin
			if (cmd.take && cmd.write) begin
				wp_q <= (wp_q == AW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != CW'(RING_DEPTH)) begin
					fill_q <= fill_q + 1'b1;
				end
				if ((d_new != '0) && !d_new[SEQ_W-1]) begin
					latest_q <= sequence_number;
				end
			end
			if (cmd.scan_start) begin
				scan_cnt_q <= CW'(1);
			end else if (cmd.scan_step) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			seq_q <= sequence_number;
		end
		if (cmd.res_load) begin
			res_q <= cmd.res_val;
		end
		if (cmd.out_load) begin
			rejected_q <= res_q;
		end
	end

	assign sts.seq_zero   = (seq_q == '0);
	assign sts.seq_later  = (d_lat != '0) && !d_lat[SEQ_W-1];
	assign sts.ring_full  = (fill_q == CW'(RING_DEPTH));
	assign sts.ring_empty = (fill_q == '0);
	assign sts.seq_older  = d_old[SEQ_W-1];
	assign sts.hit        = (rd_data_q == seq_q);
	assign sts.scan_done  = (scan_cnt_q == fill_q);
	assign rejected       = rejected_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(RING_DEPTH))
		else $error("fill count above ring depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		scan_cnt_q <= fill_q)
		else $error("scan ran past the filled entries");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && cmd.write && fill_q != CW'(RING_DEPTH)) |=>
		(fill_q == $past(fill_q) + 1'b1))
		else $error("commit did not grow the fill count");

endmodule
